FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the RTL top level.
// Depends on nothing; the checks drop out when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define YCACF_ASSERT(lbl, clk_i, rstn_i, prop) \
    lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (prop)) \
        else $error("assertion failed");
`define YCACF_ASSERT_RST(lbl, clk_i, prop) \
    lbl: assert property (@(posedge clk_i) (prop)) else $error("assertion failed");
`else
`define YCACF_ASSERT(lbl, clk_i, rstn_i, prop)
`define YCACF_ASSERT_RST(lbl, clk_i, prop)
`endif
`endif

FILE: hw/rtl/ycacf_pkg.sv
// Types and constants of the YCoCg alpha color filter decoder.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps
package ycacf_pkg;
    localparam int LANES    = 4;
    localparam int COMP_W   = 16;
    localparam int REM_W    = 33;
    localparam int DVS_W    = 17;
    localparam int NUM_W    = 37;
    localparam int CHAN_W   = 19;

    // One element in flight along the divider chain
    typedef struct packed {
        logic [LANES-1:0][REM_W-1:0]  rem;
        logic [LANES-1:0][COMP_W-1:0] quo;
        logic [LANES-1:0]             neg;
        logic [LANES-1:0]             sat;
        logic [DVS_W-1:0]             dvs;
        logic [COMP_W-1:0]            maxv;
        logic                         bad;
        logic                         last;
    } item_t;
endpackage

FILE: hw/rtl/ycacf_prep.sv
// Front cell: color transform, alpha scale and numerator setup.
// Depends on ycacf_pkg.
`timescale 1ns / 1ps
module ycacf_prep
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wide,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [63:0]         in_data,
    input  logic                in_last,
    output logic                out_valid,
    input  logic                out_ready,
    output ycacf_pkg::item_t    out_item
);
    logic                              vld_reg;
    ycacf_pkg::item_t                  item_reg;
    ycacf_pkg::item_t                  item_next;
    logic [15:0]                       y_u;
    logic [15:0]                       a_u;
    logic [15:0]                       s_v;
    logic signed [ycacf_pkg::CHAN_W-1:0] co_s;
    logic signed [ycacf_pkg::CHAN_W-1:0] cg_s;
    logic signed [ycacf_pkg::CHAN_W-1:0] y_s;
    logic signed [ycacf_pkg::CHAN_W-1:0] chan [ycacf_pkg::LANES];
    logic signed [ycacf_pkg::NUM_W-1:0]  num  [ycacf_pkg::LANES];
    logic signed [ycacf_pkg::NUM_W-1:0]  lim;
    logic signed [ycacf_pkg::NUM_W-1:0]  c_ext;
    logic                              bad;

    // Mask and sign-extend the components at the selected width
    always_comb
    begin
        y_u  = wide ? in_data[15:0] : {8'd0, in_data[7:0]};
        a_u  = wide ? in_data[63:48] : {8'd0, in_data[55:48]};
        co_s = wide ? {{3{in_data[31]}}, in_data[31:16]} : {{11{in_data[23]}}, in_data[23:16]};
        cg_s = wide ? {{3{in_data[47]}}, in_data[47:32]} : {{11{in_data[39]}}, in_data[39:32]};
        y_s  = {3'd0, y_u};
        s_v  = a_u | (a_u >> 1);
        s_v  = s_v | (s_v >> 2);
        s_v  = s_v | (s_v >> 4);
        s_v  = s_v | (s_v >> 8);
        bad  = (s_v == 16'd0);
        chan[0] = y_s + co_s - cg_s;
        chan[1] = y_s + cg_s;
        chan[2] = y_s - co_s - cg_s;
        chan[3] = {3'd0, (((a_u << 1) & s_v) | {15'd0, a_u[0]})};
    end

    // Form 2*c*MAX + S and flag the clamped cases
    always_comb
    begin
        item_next      = '0;
        item_next.dvs  = {s_v, 1'b0};
        item_next.maxv = wide ? 16'hFFFF : 16'h00FF;
        item_next.bad  = bad;
        item_next.last = in_last;
        lim = wide ? ({20'd0, s_v, 1'b0} <<< 16) : ({20'd0, s_v, 1'b0} <<< 8);
        for (int i = 0; i < ycacf_pkg::LANES; i++)
        begin
            c_ext  = {{(ycacf_pkg::NUM_W-ycacf_pkg::CHAN_W){chan[i][ycacf_pkg::CHAN_W-1]}}, chan[i]};
            num[i] = (wide ? (c_ext <<< 17) : (c_ext <<< 9)) - (c_ext <<< 1)
                     + {21'd0, s_v};
            item_next.neg[i] = bad | num[i][ycacf_pkg::NUM_W-1];
            item_next.sat[i] = (num[i] >= lim);
            item_next.rem[i] = num[i][ycacf_pkg::REM_W-1:0];
        end
    end

    assign in_ready  = !vld_reg || out_ready;
    assign out_valid = vld_reg;
    assign out_item  = item_reg;

    // Advance the element when the next cell has room
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= item_next;
        end
    end
endmodule

FILE: hw/rtl/ycacf_div_cell.sv
// Divider cell: one restoring quotient bit for all four channels.
// Depends on ycacf_pkg.
`timescale 1ns / 1ps
module ycacf_div_cell
#(
    parameter int BIT = 15
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  ycacf_pkg::item_t in_item,
    output logic             out_valid,
    input  logic             out_ready,
    output ycacf_pkg::item_t out_item
);
    logic                          vld_reg;
    ycacf_pkg::item_t              item_reg;
    ycacf_pkg::item_t              item_next;
    logic [ycacf_pkg::REM_W-1:0]   trial;

    // Subtract the shifted divisor where it fits and set the quotient bit
    always_comb
    begin
        item_next = in_item;
        trial     = {{(ycacf_pkg::REM_W-ycacf_pkg::DVS_W){1'b0}}, in_item.dvs} << BIT;
        for (int i = 0; i < ycacf_pkg::LANES; i++)
        begin
            if (in_item.rem[i] >= trial)
            begin
                item_next.rem[i]      = in_item.rem[i] - trial;
                item_next.quo[i][BIT] = 1'b1;
            end
        end
    end

    assign in_ready  = !vld_reg || out_ready;
    assign out_valid = vld_reg;
    assign out_item  = item_reg;

    // Hand the element to the neighbor when it has room
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= item_next;
        end
    end
endmodule

FILE: hw/rtl/ycacf_pkg_unused_guard.sv
// Output stage: clamp and pack the decoded channels.
// Depends on ycacf_pkg.
`timescale 1ns / 1ps
module ycacf_out_pack
(
    input  ycacf_pkg::item_t item,
    output logic [63:0]      data,
    output logic             bad
);
    // Pick zero, the maximum or the quotient per channel
    always_comb
    begin
        for (int i = 0; i < ycacf_pkg::LANES; i++)
        begin
            if (item.neg[i])
            begin
                data[i*16 +: 16] = 16'd0;
            end
            else if (item.sat[i])
            begin
                data[i*16 +: 16] = item.maxv;
            end
            else
            begin
                data[i*16 +: 16] = item.quo[i];
            end
        end
        bad = item.bad;
    end
endmodule

FILE: hw/rtl/ycocg_alpha_color_filter_decode_unit.sv
// Top level of the YCoCg alpha color filter decoder.
// Depends on ycacf_pkg, ycacf_prep, ycacf_div_cell, ycacf_out_pack, assert_macros.svh.
//
// Decodes YCoCg + coded alpha elements into clamped RGBA, taking a new
// element every cycle while the output is drained. An element passes a
// setup cell and then a row of 16 divider cells, each settling one quotient
// bit and registering the element. Each cell holds its element until the
// next has room. wide_components must be set through cfg_we/cfg_wdata only
// while no element is in flight; the block does not enforce it. A zero
// coded alpha gives all-zero channels with tuser set.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ycocg_alpha_color_filter_decode_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // luma, chroma_orange, chroma_green, coded_alpha
    input  logic        s_tlast,   // last_element
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // red, green, blue, alpha_out
    output logic        m_tuser,   // bad_alpha
    output logic        m_tlast    // last_out
);
    localparam int CELLS = ycacf_pkg::COMP_W;

    logic             wide_reg;
    logic             vld  [CELLS+1];
    logic             rdy  [CELLS+1];
    ycacf_pkg::item_t item [CELLS+1];

    // Hold the width register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wide_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            wide_reg <= cfg_wdata;
        end
    end

    ycacf_prep u_prep
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .wide      (wide_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (s_tdata),
        .in_last   (s_tlast),
        .out_valid (vld[0]),
        .out_ready (rdy[0]),
        .out_item  (item[0])
    );

    // Divider row, most significant quotient bit first
    for (genvar j = 0; j < CELLS; j++)
    begin : g_cell
        ycacf_div_cell #(.BIT(CELLS - 1 - j)) u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (vld[j]),
            .in_ready  (rdy[j]),
            .in_item   (item[j]),
            .out_valid (vld[j+1]),
            .out_ready (rdy[j+1]),
            .out_item  (item[j+1])
        );
    end

    assign rdy[CELLS] = m_tready;
    assign m_tvalid   = vld[CELLS];
    assign m_tlast    = item[CELLS].last;

    ycacf_out_pack u_pack
    (
        .item (item[CELLS]),
        .data (m_tdata),
        .bad  (m_tuser)
    );

    `YCACF_ASSERT(a_bad_zero, clk, rst_n, (m_tvalid && m_tuser) |-> (m_tdata == 64'd0))
    `YCACF_ASSERT(a_narrow_range, clk, rst_n, (m_tvalid && !wide_reg) |-> ((m_tdata[15:8] == 8'd0) && (m_tdata[31:24] == 8'd0) && (m_tdata[47:40] == 8'd0) && (m_tdata[63:56] == 8'd0)))
    `YCACF_ASSERT_RST(a_reset_idle, clk, !rst_n |-> !m_tvalid)
endmodule

FILE: sim/ycocg_alpha_color_filter_decode_unit_tb.sv
// Testbench for the YCoCg alpha color filter decoder: directed and random elements
// in both component widths, with a scoreboard that predicts each decoded color.
// Depends on the RTL top ycocg_alpha_color_filter_decode_unit only.
`timescale 1ns / 1ps

class color_scoreboard;
    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic [15:0] alpha;
        logic        bad;
        logic        last;
    } pixel_t;

    pixel_t pending[$];
    bit     wide;
    int     errors;

    // Scale one channel by max/scale with half-up rounding, clamp to 0..max
    function automatic logic [15:0] scale_chan(longint c, longint maxv, longint s);
        longint num;
        longint q;
        num = 2 * c * maxv + s;
        if (num < 0)
            return 16'd0;
        q = num / (2 * s);
        if (q > maxv)
            q = maxv;
        return q[15:0];
    endfunction

    function automatic longint sext(logic [15:0] raw);
        if (wide)
            return longint'($signed(raw));
        return longint'($signed(raw[7:0]));
    endfunction

    // Predict the decoded color of one accepted element
    function void note_element(logic [63:0] data, logic last);
        longint maxv;
        longint y;
        longint co;
        longint cg;
        longint a;
        longint s;
        pixel_t p;
        maxv = wide ? 65535 : 255;
        y  = data[15:0] & maxv;
        co = sext(data[31:16]);
        cg = sext(data[47:32]);
        a  = data[63:48] & maxv;
        s  = a;
        s  = s | (s >> 1);
        s  = s | (s >> 2);
        s  = s | (s >> 4);
        s  = s | (s >> 8);
        p = '0;
        p.last = last;
        if (s == 0)
            p.bad = 1'b1;
        else
        begin
            p.red   = scale_chan(y + co - cg, maxv, s);
            p.green = scale_chan(y + cg, maxv, s);
            p.blue  = scale_chan(y - co - cg, maxv, s);
            p.alpha = scale_chan(((a << 1) & s) | (a & 1), maxv, s);
        end
        pending.push_back(p);
    endfunction

    // Compare one output transfer with the oldest prediction
    function void check_pixel(logic [63:0] data, logic bad, logic last);
        pixel_t exp_p;
        pixel_t got;
        got = {data[15:0], data[31:16], data[47:32], data[63:48], bad, last};
        if (pending.size() == 0)
        begin
            $display("%0t: unexpected output %h", $time, got);
            errors++;
            return;
        end
        exp_p = pending.pop_front();
        if (got !== exp_p)
        begin
            $display("%0t: mismatch expected %h actual %h", $time, exp_p, got);
            errors++;
        end
    endfunction
endclass

module ycocg_alpha_color_filter_decode_unit_tb;
    localparam int LATENCY = 17;
    localparam int STALL_LIMIT = 2000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    color_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    int quiet_cycles;

    ycocg_alpha_color_filter_decode_unit dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tlast(s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Check output transfers, randomize backpressure, watch for stalls
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_pixel(m_tdata, m_tuser, m_tlast);
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("[ycocg_alpha_color_filter_decode_unit] ERROR");
                $finish;
            end
        end
    end

    // Offer one element and hold it until transferred; drop valid while idling
    task automatic send_element(logic [63:0] data, logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_element(data, last);
    endtask

    // Drain the pipeline, then change the width register
    task automatic set_width(bit w);
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= w;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.wide = w;
    endtask

    function automatic logic [15:0] rand_comp();
        case ($urandom_range(5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h0080 ^ 16'($urandom_range(3));
            3: return 16'h8000 ^ 16'($urandom_range(3));
            default: return 16'($urandom);
        endcase
    endfunction

    // Mostly valid alphas, with zeros and small scales mixed in
    function automatic logic [15:0] rand_alpha();
        case ($urandom_range(7))
            0: return 16'h0000;
            1: return 16'($urandom_range(7));
            2: return 16'h0001 << $urandom_range(15);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic run_random(int count);
        for (int i = 0; i < count; i++)
            send_element({rand_alpha(), rand_comp(), rand_comp(), rand_comp()},
                         1'($urandom_range(1)));
    endtask

    task automatic run_directed();
        send_element({16'h00FF, 16'h0000, 16'h0000, 16'h0000}, 1'b0);
        send_element({16'h00FF, 16'h0000, 16'h0000, 16'h00FF}, 1'b1);
        send_element({16'h0000, 16'h0011, 16'h0022, 16'h0033}, 1'b1);
        send_element({16'hFF00, 16'h0011, 16'h0022, 16'h0033}, 1'b0);
        send_element({16'h0001, 16'h007F, 16'h0080, 16'h00FF}, 1'b0);
        send_element({16'h0001, 16'h0080, 16'h007F, 16'h0000}, 1'b1);
        send_element({16'hFFFF, 16'h8000, 16'h7FFF, 16'hFFFF}, 1'b0);
        send_element({16'h8000, 16'h7FFF, 16'h8000, 16'h0000}, 1'b0);
        send_element({16'h0002, 16'hFF7F, 16'hAB80, 16'h5555}, 1'b1);
        send_element({16'h0003, 16'h0040, 16'h0001, 16'h0010}, 1'b0);
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        quiet_cycles = 0;
        send_idle_pct = 12;
        recv_idle_pct = 47;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Narrow components at reset value, then wide
        run_directed();
        set_width(1'b0);
        run_random(110);
        set_width(1'b1);
        run_directed();
        run_random(110);

        send_idle_pct = 47;
        recv_idle_pct = 12;
        set_width(1'b0);
        run_random(100);
        set_width(1'b1);
        run_random(100);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_width(1'b0);
        run_random(100);
        set_width(1'b1);
        run_random(100);

        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);
        if (sb.errors == 0)
            $display("[ycocg_alpha_color_filter_decode_unit] OK");
        else
            $display("[ycocg_alpha_color_filter_decode_unit] ERROR");
        $finish;
    end
endmodule
